FILE: design/pbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and constants of the perceptron branch predictor: operation
// codes, field widths, weight limits and the weight memory control bundle.
// ----------------------------------------------------------------------------
package pbp_pkg;

   // Request and response field widths.
   localparam int OP_W     = 3;
   localparam int THREAD_W = 2;
   localparam int PC_W     = 64;
   localparam int SNAP_W   = 16;
   localparam int OUT_W    = 12;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNCOND   = 3'd1;
   localparam logic [OP_W-1:0] OP_BTB_MISS = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTORE  = 3'd3;
   localparam logic [OP_W-1:0] OP_RESOLVE  = 3'd4;

   // Weights are signed 7-bit values that saturate.
   localparam int W_W = 7;
   localparam logic signed [W_W-1:0] W_MAX = 7'h3f;
   localparam logic signed [W_W-1:0] W_MIN = 7'h40;

   // The accumulator covers 64 weights of magnitude 64 at most.
   localparam int SUM_W = 14;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 12'h7ff;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 12'h800;

   // Weights added per accumulation cycle.
   localparam int LANES = 8;

   // Control bundle from the sequencer to the weight memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic taken;
   } wctl_type;

endpackage
`default_nettype wire

FILE: design/pbp_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_index
// Reduces the 64-bit row key modulo the table size. A power-of-two table
// takes the low bits into a register; any other size is reduced one byte
// a cycle, most significant byte first, over the eight key bytes, with a
// reciprocal multiplication and one correcting subtraction per byte.
// ----------------------------------------------------------------------------
module pbp_index #(
   parameter int TABLE_ENTRIES = 256,
   parameter int IDX_W         = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [pbp_pkg::PC_W-1:0] key,
   output logic                          done,
   output logic [IDX_W-1:0]              index
);
   import pbp_pkg::*;

   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   if (IS_POW2) begin : g_mask
      logic             done_ff;
      logic [IDX_W-1:0] index_ff;

      // The index is simply the low key bits.
      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            index_ff <= key[IDX_W-1:0];
         end
      end

      assign done  = done_ff;
      assign index = index_ff;
   end else begin : g_reduce
      localparam int DIGIT_W = 8;
      localparam int DIGITS  = PC_W / DIGIT_W;
      localparam int CNT_W   = $clog2(DIGITS);
      localparam int T_W     = IDX_W + DIGIT_W;
      localparam int RCP_W   = DIGIT_W + 1;
      localparam int PROD_W  = T_W + RCP_W;
      localparam longint RCP_VAL = (longint'(1) << T_W) / longint'(TABLE_ENTRIES);
      localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RCP_VAL);
      localparam logic [T_W-1:0]   MODULUS = T_W'(TABLE_ENTRIES);

      logic             busy_ff, busy_in;
      logic             done_ff, done_in;
      logic [CNT_W-1:0] cnt_ff, cnt_in;
      logic [PC_W-1:0]  key_ff, key_in;
      logic [IDX_W-1:0] rem_ff, rem_in, rem_step;
      logic [T_W-1:0]    t_val, q_m, diff;
      logic [PROD_W-1:0] prod;
      logic [RCP_W-1:0]  q_est;

      // Fold one byte into the remainder. The reciprocal estimate of the
      // quotient is low by at most one, so one compare and subtract ends it.
      always_comb begin : digit_step
         t_val    = {rem_ff, key_ff[PC_W-1 -: DIGIT_W]};
         prod     = PROD_W'(t_val) * PROD_W'(RECIP);
         q_est    = prod[PROD_W-1 -: RCP_W];
         q_m      = T_W'(q_est) * MODULUS;
         diff     = t_val - q_m;
         if (diff >= MODULUS) begin
            diff = diff - MODULUS;
         end
         rem_step = diff[IDX_W-1:0];
      end

      // Sequencing of the eight byte steps.
      always_comb begin
         busy_in = busy_ff;
         done_in = 1'b0;
         cnt_in  = cnt_ff;
         key_in  = key_ff;
         rem_in  = rem_ff;
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            key_in  = key;
            rem_in  = '0;
         end else if (busy_ff) begin
            key_in = key_ff << DIGIT_W;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
         end else begin
            busy_ff <= busy_in;
            done_ff <= done_in;
            cnt_ff  <= cnt_in;
         end
      end

      always_ff @(posedge clock) begin
         key_ff <= key_in;
         rem_ff <= rem_in;
      end

      assign done  = done_ff;
      assign index = rem_ff;
   end

endmodule
`default_nettype wire

FILE: design/pbp_weights.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_weights
// Weight memory, one row of weights per entry, with a registered read port
// and one write port. After reset a sweep writes the initial weight into
// every row. A training write stores the row last read, with each weight
// moved one step toward the outcome and saturated.
// ----------------------------------------------------------------------------
module pbp_weights #(
   parameter int HISTORY_BITS  = 16,
   parameter int TABLE_ENTRIES = 256,
   parameter int IDX_W         = 8,
   parameter int INIT_WEIGHT   = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pbp_pkg::wctl_type                     ctl,
   input  wire logic [IDX_W-1:0]                      addr,
   input  wire logic [HISTORY_BITS-1:0]               train_hist,
   output logic [HISTORY_BITS*pbp_pkg::W_W-1:0]       row,
   output logic                                       clearing
);
   import pbp_pkg::*;

   localparam int ROW_W = HISTORY_BITS * W_W;
   localparam logic [W_W-1:0]   INIT_W   = W_W'(INIT_WEIGHT);
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TABLE_ENTRIES - 1);

   logic [ROW_W-1:0] mem [TABLE_ENTRIES];
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] trained;
   logic [ROW_W-1:0] wr_data;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   // Training update: each weight steps up when its history bit agrees with
   // the outcome and down otherwise. The bias counts as a history bit of one.
   always_comb begin : train_row
      logic signed [W_W-1:0] w;
      logic                  up;
      trained = '0;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         w  = row_ff[i*W_W +: W_W];
         up = ((i == HISTORY_BITS - 1) ? 1'b1 : train_hist[i]) == ctl.taken;
         if (up) begin
            if (w != W_MAX) begin
               w = w + W_W'(1);
            end
         end else if (w != W_MIN) begin
            w = w - W_W'(1);
         end
         trained[i*W_W +: W_W] = w;
      end
   end

   // Clearing sweep after reset, one row per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == LAST_ROW) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   // Write port is shared by the sweep and training.
   assign wr_en   = clearing_ff | ctl.wr_en;
   assign wr_addr = clearing_ff ? clr_ff : addr;
   assign wr_data = clearing_ff ? {HISTORY_BITS{INIT_W}} : trained;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         row_ff <= mem[addr];
      end
   end

   assign row      = row_ff;
   assign clearing = clearing_ff;

endmodule
`default_nettype wire

FILE: design/pbp_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_sum
// Perceptron dot product. Each weight is signed by its history bit, the
// last weight is the bias, and eight terms are accumulated per cycle. The
// result saturates to the 12-bit output range.
// ----------------------------------------------------------------------------
module pbp_sum #(
   parameter int HISTORY_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [HISTORY_BITS*pbp_pkg::W_W-1:0]    row,
   input  wire logic [HISTORY_BITS-1:0]                 hist,
   output logic                                         done,
   output logic signed [pbp_pkg::OUT_W-1:0]             sum
);
   import pbp_pkg::*;

   localparam int CHUNKS = (HISTORY_BITS + LANES - 1) / LANES;
   localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int TERM_W = W_W + 1;

   logic signed [TERM_W-1:0] terms [CHUNKS][LANES];
   logic signed [SUM_W-1:0]  acc_ff, acc_in, chunk_sum;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   // Signed terms; lanes past the last weight contribute nothing.
   for (genvar gc = 0; gc < CHUNKS; gc++) begin : g_chunk
      for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
         localparam int K = gc * LANES + gl;
         if (K < HISTORY_BITS) begin : g_live
            logic signed [TERM_W-1:0] w_ext;
            assign w_ext = {row[K*W_W + W_W - 1], row[K*W_W +: W_W]};
            if (K == HISTORY_BITS - 1) begin : g_bias
               assign terms[gc][gl] = w_ext;
            end else begin : g_pair
               assign terms[gc][gl] = hist[K] ? w_ext : -w_ext;
            end
         end else begin : g_pad
            assign terms[gc][gl] = '0;
         end
      end
   end

   // Sum of the current chunk.
   always_comb begin
      chunk_sum = '0;
      for (int j = 0; j < LANES; j++) begin
         chunk_sum = chunk_sum + SUM_W'(terms[cnt_ff][j]);
      end
   end

   // Accumulation over the chunks.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + chunk_sum;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CHUNKS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Saturate to the output range.
   always_comb begin
      if (acc_ff > SUM_W'(OUT_MAX)) begin
         sum = OUT_MAX;
      end else if (acc_ff < SUM_W'(OUT_MIN)) begin
         sum = OUT_MIN;
      end else begin
         sum = acc_ff[OUT_W-1:0];
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

FILE: design/perceptron_branch_predictor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Perceptron branch predictor with one global history register per thread.
// Rows of signed weights sit in a synchronous two-port memory; lookups
// sum a row, resolves read a row and write it back when it must train.
//
//   Channel   Ports                     Transfer
//   request   start, busy, req_*        start high while busy is low
//   response  rsp_valid, rsp_*          rsp_valid high, one cycle, no stall
//
// History-only operations (unconditional, BTB miss, restore, squashed
// resolve) answer in the next cycle and leave busy low.
// An unsquashed resolve passes the row index and the memory read, then
// writes the row back only if it trains; a lookup passes the row index,
// the memory read and the eight-term accumulator.
// When TABLE_ENTRIES is not a power of two, the row index goes byte by byte.
// After reset, busy stays high while every row is written with the
// initial weight.
// The response cannot be held off, and busy is the only stall.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor #(
   parameter int HISTORY_BITS  = 16,
   parameter int TABLE_ENTRIES = 256,
   parameter int INST_SHIFT    = 2,
   parameter int THREADS       = 4,
   parameter int INIT_WEIGHT   = 0
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [pbp_pkg::OP_W-1:0]             req_op,
   input  wire logic [pbp_pkg::THREAD_W-1:0]         req_thread,
   input  wire logic [pbp_pkg::PC_W-1:0]             req_pc,
   input  wire logic                                 req_taken,
   input  wire logic                                 req_squashed,
   input  wire logic [pbp_pkg::SNAP_W-1:0]           req_saved_history,
   input  wire logic signed [pbp_pkg::OUT_W-1:0]     req_saved_output,
   output logic                                      rsp_valid,
   output logic                                      rsp_predict_taken,
   output logic [pbp_pkg::SNAP_W-1:0]                rsp_history_snapshot,
   output logic signed [pbp_pkg::OUT_W-1:0]          rsp_output_value
);
   import pbp_pkg::*;

   localparam int IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int TID_W      = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int THR_FULL_W = 5;
   localparam int MAG_W      = OUT_W + 1;
   localparam int THRESHOLD  = 2 * HISTORY_BITS + 14;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_INDEX = 2'd1;
   localparam logic [1:0] ST_ROW   = 2'd2;
   localparam logic [1:0] ST_SUM   = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic                    accept;
   logic                    table_op;
   logic [THR_FULL_W-1:0]   thr_full;
   logic [TID_W-1:0]        tid;
   logic [HISTORY_BITS-1:0] thread_hist_ff [THREADS];
   logic [HISTORY_BITS-1:0] hist_cur, hist_in, saved_h, key_hist;
   logic                    hist_wr;
   logic [PC_W-1:0]         key;

   // Item registers.
   logic [OP_W-1:0]         op_ff, op_in;
   logic [HISTORY_BITS-1:0] hist_q_ff, hist_q_in;
   logic [HISTORY_BITS-1:0] saved_ff, saved_in;
   logic                    taken_ff, taken_in;
   logic [OUT_W-1:0]        saved_out_ff, saved_out_in;

   // Response registers.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pred_ff, rsp_pred_in;
   logic [SNAP_W-1:0]       rsp_snap_ff, rsp_snap_in;
   logic [OUT_W-1:0]        rsp_val_ff, rsp_val_in;

   // Submodule connections.
   logic                           idx_start, idx_done;
   logic [IDX_W-1:0]               idx;
   wctl_type                       wctl;
   logic [HISTORY_BITS*W_W-1:0]    row;
   logic                           clearing;
   logic                           sum_start, sum_done;
   logic signed [OUT_W-1:0]        sum;

   // Training decision.
   logic                    so_neg, correct, train_need;
   logic [MAG_W-1:0]        so_ext, mag;

   assign busy   = (state_ff != ST_IDLE) | clearing;
   assign accept = start & ~busy;

   // Thread index wraps modulo the thread count.
   always_comb begin
      thr_full = THR_FULL_W'(req_thread);
      if (THREADS == 1) begin
         thr_full = '0;
      end else if (thr_full >= THR_FULL_W'(THREADS)) begin
         thr_full = thr_full - THR_FULL_W'(THREADS);
      end
      tid = thr_full[TID_W-1:0];
   end

   assign hist_cur = thread_hist_ff[tid];
   assign saved_h  = HISTORY_BITS'(req_saved_history);
   assign table_op = (req_op == OP_LOOKUP) | ((req_op == OP_RESOLVE) & ~req_squashed);
   assign key_hist = (req_op == OP_LOOKUP) ? hist_cur : saved_h;
   assign key      = (req_pc >> INST_SHIFT) ^ PC_W'(key_hist);
   assign idx_start = accept & table_op;

   // History update decoder, applied on the accepting edge.
   always_comb begin
      hist_wr = 1'b0;
      hist_in = hist_cur;
      unique case (req_op)
         OP_UNCOND: begin
            hist_wr = 1'b1;
            hist_in = {hist_cur[HISTORY_BITS-2:0], 1'b1};
         end
         OP_BTB_MISS: begin
            hist_wr = 1'b1;
            hist_in = {hist_cur[HISTORY_BITS-1:1], 1'b0};
         end
         OP_RESTORE: begin
            hist_wr = 1'b1;
            hist_in = saved_h;
         end
         OP_RESOLVE: begin
            hist_wr = req_squashed;
            hist_in = {saved_h[HISTORY_BITS-2:0], req_taken};
         end
         default: begin
            hist_wr = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < THREADS; t++) begin
            thread_hist_ff[t] <= '1;
         end
      end else if (accept & hist_wr) begin
         thread_hist_ff[tid] <= hist_in;
      end
   end

   // Train on a misprediction or a low-confidence sum.
   assign so_neg     = saved_out_ff[OUT_W-1];
   assign correct    = taken_ff == ~so_neg;
   assign so_ext     = {saved_out_ff[OUT_W-1], saved_out_ff};
   assign mag        = so_neg ? (MAG_W'(0) - so_ext) : so_ext;
   assign train_need = ~correct | (mag < MAG_W'(THRESHOLD));

   // Item capture.
   always_comb begin
      op_in        = op_ff;
      hist_q_in    = hist_q_ff;
      saved_in     = saved_ff;
      taken_in     = taken_ff;
      saved_out_in = saved_out_ff;
      if (accept) begin
         op_in        = req_op;
         hist_q_in    = hist_cur;
         saved_in     = saved_h;
         taken_in     = req_taken;
         saved_out_in = req_saved_output;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_pred_in  = rsp_pred_ff;
      rsp_snap_in  = rsp_snap_ff;
      rsp_val_in   = rsp_val_ff;
      wctl         = '0;
      wctl.taken   = taken_ff;
      sum_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (table_op) begin
                  state_in = ST_INDEX;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_pred_in  = req_op == OP_UNCOND;
                  rsp_snap_in  = SNAP_W'(hist_cur);
                  rsp_val_in   = '0;
               end
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               wctl.rd_en = 1'b1;
               state_in   = ST_ROW;
            end
         end
         ST_ROW: begin
            if (op_ff == OP_LOOKUP) begin
               sum_start = 1'b1;
               state_in  = ST_SUM;
            end else begin
               wctl.wr_en   = train_need;
               rsp_valid_in = 1'b1;
               rsp_pred_in  = 1'b0;
               rsp_snap_in  = SNAP_W'(hist_q_ff);
               rsp_val_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (sum_done) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = ~sum[OUT_W-1];
               rsp_snap_in  = SNAP_W'(hist_q_ff);
               rsp_val_in   = sum;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      hist_q_ff    <= hist_q_in;
      saved_ff     <= saved_in;
      taken_ff     <= taken_in;
      saved_out_ff <= saved_out_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_snap_ff  <= rsp_snap_in;
      rsp_val_ff   <= rsp_val_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_pred_ff;
   assign rsp_history_snapshot = rsp_snap_ff;
   assign rsp_output_value     = rsp_val_ff;

   // Row index unit.
   pbp_index #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_index (
      .clock (clock),
      .reset (reset),
      .start (idx_start),
      .key   (key),
      .done  (idx_done),
      .index (idx)
   );

   // Weight memory with clearing sweep and training write-back.
   pbp_weights #(
      .HISTORY_BITS  (HISTORY_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .INIT_WEIGHT   (INIT_WEIGHT)
   ) u_weights (
      .clock      (clock),
      .reset      (reset),
      .ctl        (wctl),
      .addr       (idx),
      .train_hist (saved_ff),
      .row        (row),
      .clearing   (clearing)
   );

   // Dot-product accumulator.
   pbp_sum #(
      .HISTORY_BITS (HISTORY_BITS)
   ) u_sum (
      .clock (clock),
      .reset (reset),
      .start (sum_start),
      .row   (row),
      .hist  (hist_q_ff),
      .done  (sum_done),
      .sum   (sum)
   );

   // The clearing sweep runs with no item in flight.
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing |-> state_ff == ST_IDLE)
      else $error("weight sweep overlaps an item");

   // The row index completes only while the sequencer waits for it.
   a_index_wait: assert property (@(posedge clock) disable iff (reset)
      idx_done |-> state_ff == ST_INDEX)
      else $error("row index completed outside the index wait");

   // The sum completes only while the sequencer waits for it.
   a_sum_wait: assert property (@(posedge clock) disable iff (reset)
      sum_done |-> state_ff == ST_SUM)
      else $error("sum completed outside the sum wait");

   // Training writes come only from an unsquashed resolve with its row read.
   a_train_write: assert property (@(posedge clock) disable iff (reset)
      wctl.wr_en |-> (state_ff == ST_ROW) && (op_ff == OP_RESOLVE) && !clearing)
      else $error("training write outside a resolve");

   // Every response follows an accept or the end of a table operation.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept || state_ff == ST_ROW || state_ff == ST_SUM))
      else $error("response without a cause");

endmodule
`default_nettype wire
